FILE: sv/melody_note_sequencer_macros.svh
// assertion macros for the melody note sequencer
// used by the top level; no other dependencies
`ifndef MELODY_NOTE_SEQUENCER_MACROS_SVH
`define MELODY_NOTE_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MNS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mns assertion failed");
// next-cycle implication
`define MNS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mns assertion failed");
`else
`define MNS_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define MNS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

FILE: sv/mns_pkg.sv
// shared types, constants and note table for the melody note sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mns_pkg;

  localparam int NOTE_COUNT = 8;
  localparam int TABLE_SIZE = 8;
  localparam int LEN_CAP = (NOTE_COUNT < TABLE_SIZE) ? NOTE_COUNT : TABLE_SIZE;

  localparam int FREQ_W   = 14;
  localparam int DUR_W    = 8;
  localparam int ELAPSED_W = 16;
  localparam int IDX_W    = 3;
  localparam int LEN_W    = 4;
  localparam int STATE_W  = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [ELAPSED_W-1:0] PAUSE_MS_RESET = 16'd150;
  localparam logic [LEN_W-1:0]     MELODY_LEN_RESET = 4'd8;
  localparam logic [LEN_W-1:0]     LEN_CAP_V = LEN_W'(LEN_CAP);

  // register index, taken from paddr[2]
  localparam logic REG_PAUSE_MS   = 1'b0;
  localparam logic REG_MELODY_LEN = 1'b1;

  // player_state codes on the result beat
  localparam logic [STATE_W-1:0] ST_PLAYING  = 2'd0;
  localparam logic [STATE_W-1:0] ST_PAUSING  = 2'd1;
  localparam logic [STATE_W-1:0] ST_FINISHED = 2'd2;

  typedef enum logic [2:0] {
    MODE_PLAYING  = 3'b001,
    MODE_PAUSING  = 3'b010,
    MODE_FINISHED = 3'b100
  } mode_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] pause_ms;
    logic [LEN_W-1:0]     melody_length;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  tone_frequency;
    logic               tone_on;
    logic               note_started;
    logic [STATE_W-1:0] player_state;
    logic [IDX_W-1:0]   note_position;
  } result_t;

  function automatic logic [FREQ_W-1:0] note_freq(input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    case (idx)
      3'd0:    f = 14'd262;
      3'd1:    f = 14'd196;
      3'd2:    f = 14'd196;
      3'd3:    f = 14'd220;
      3'd4:    f = 14'd196;
      3'd5:    f = 14'd0;
      3'd6:    f = 14'd247;
      3'd7:    f = 14'd262;
      default: f = 14'd0;
    endcase
    return f;
  endfunction

  function automatic logic [DUR_W-1:0] note_dur(input logic [IDX_W-1:0] idx);
    logic [DUR_W-1:0] d;
    case (idx)
      3'd1, 3'd2: d = 8'd125;
      default:    d = 8'd250;
    endcase
    return d;
  endfunction

  function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
    logic [STATE_W-1:0] c;
    case (m)
      MODE_PLAYING: c = ST_PLAYING;
      MODE_PAUSING: c = ST_PAUSING;
      default:      c = ST_FINISHED;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mns_tick_if.sv
// input channel: one beat per millisecond tick
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface mns_tick_if;
  logic valid;
  logic ready;
  logic start_request;

  modport source(output valid, output start_request, input ready);
  modport sink(input valid, input start_request, output ready);
endinterface
`default_nettype wire

FILE: sv/mns_note_if.sv
// result channel: one beat per accepted tick
// depends on mns_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface mns_note_if import mns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FREQ_W-1:0]  tone_frequency;
  logic               tone_on;
  logic               note_started;
  logic [STATE_W-1:0] player_state;
  logic [IDX_W-1:0]   note_position;

  modport source(output valid, output tone_frequency, output tone_on,
                 output note_started, output player_state, output note_position,
                 input ready);
  modport sink(input valid, input tone_frequency, input tone_on,
               input note_started, input player_state, input note_position,
               output ready);
endinterface
`default_nettype wire

FILE: sv/mns_cfg.sv
// apb-style register block: pause_ms and melody_length
// depends on mns_pkg
`timescale 1ns / 1ps
`default_nettype none
module mns_cfg import mns_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pause_ms      <= PAUSE_MS_RESET;
      cfg.melody_length <= MELODY_LEN_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PAUSE_MS:   cfg.pause_ms      <= pwdata[ELAPSED_W-1:0];
        REG_MELODY_LEN: cfg.melody_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PAUSE_MS:   prdata = APB_DATA_W'(cfg.pause_ms);
      REG_MELODY_LEN: prdata = APB_DATA_W'(cfg.melody_length);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/mns_core.sv
// player state registers and per-tick next-state logic
// depends on mns_pkg (note table, mode encoding)
`timescale 1ns / 1ps
`default_nettype none
module mns_core import mns_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire logic start_request,
  input  cfg_t      cfg,
  output result_t   result
);

  mode_t                mode, mode_next;
  logic [IDX_W-1:0]     note_idx, note_idx_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;

  logic [ELAPSED_W-1:0] el_inc;
  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     note_plus1;
  logic                 started;
  logic [FREQ_W-1:0]    freq_new;
  logic [DUR_W-1:0]     dur_new;

  always_comb begin
    // saturated length, zero treated as one
    if (cfg.melody_length > LEN_CAP_V) len_eff = LEN_CAP_V;
    else if (cfg.melody_length == '0)  len_eff = LEN_W'(1);
    else                               len_eff = cfg.melody_length;
  end

  assign el_inc     = (elapsed == ELAPSED_MAX) ? ELAPSED_MAX : elapsed + 1'b1;
  assign note_plus1 = LEN_W'(note_idx) + LEN_W'(1);

  always_comb begin
    mode_next     = mode;
    note_idx_next = note_idx;
    elapsed_next  = el_inc;
    started       = 1'b0;
    if (start_request && mode != MODE_PLAYING) begin
      mode_next     = MODE_PLAYING;
      note_idx_next = '0;
      elapsed_next  = '0;
      started       = 1'b1;
    end else if (mode == MODE_PLAYING) begin
      if (el_inc > ELAPSED_W'(note_dur(note_idx))) begin
        if (note_plus1 >= len_eff) begin
          mode_next = MODE_FINISHED;
        end else begin
          mode_next     = MODE_PAUSING;
          elapsed_next  = '0;
          note_idx_next = note_idx + 1'b1;
        end
      end
    end else if (mode == MODE_PAUSING) begin
      if (el_inc > cfg.pause_ms) begin
        mode_next    = MODE_PLAYING;
        elapsed_next = '0;
        started      = 1'b1;
      end
    end
  end

  assign freq_new = note_freq(note_idx_next);
  assign dur_new  = note_dur(note_idx_next);

  always_comb begin
    result.tone_frequency = freq_new;
    result.tone_on        = (mode_next == MODE_PLAYING) && (freq_new != '0) &&
                            (elapsed_next < ELAPSED_W'(dur_new));
    result.note_started   = started;
    result.player_state   = mode_code(mode_next);
    result.note_position  = note_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_FINISHED;
      note_idx <= '0;
      elapsed  <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      note_idx <= note_idx_next;
      elapsed  <= elapsed_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mns_obuf.sv
// two-entry result buffer between the core and the result channel
// depends on mns_pkg (result_t)
`timescale 1ns / 1ps
`default_nettype none
module mns_obuf import mns_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  result_t   d,
  output logic      ready,
  output logic      q_valid,
  input  wire logic pop,
  output result_t   q
);

  result_t    slot0, slot1;
  logic [1:0] count;

  assign ready   = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q       = slot0;

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= d;
        else               slot1 <= d;
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        // one held: the new beat replaces it at the head
        if (count == 2'd1) slot0 <= d;
        else begin
          slot0 <= slot1;
          slot1 <= d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/melody_note_sequencer.sv
// melody note sequencer top level
// usage:
//   tick channel: one beat per millisecond, start_request asks to (re)start
//   the melody at note 0; ignored while a note is playing
//   note channel: one result beat per tick beat, carrying the frequency for
//   the tone generator (0 is rest), tone_on, a note_started pulse, the
//   player state (0 playing, 1 pausing, 2 finished) and the note index
//   apb port: pause_ms at 0x0, melody_length at 0x4, written in the access
//   cycle; pready is tied high and reads return the register value
// timing:
//   a tick beat is taken in any cycle the result buffer has room; its result
//   is registered into the buffer, so throughput is one beat per cycle while
//   the buffer has room, set by the single state update in the core
//   a two-entry buffer holds results while the receiver stalls; tick ready
//   drops only when both entries are full, so no beat is lost
// reset:
//   synchronous rst returns to finished at note 0 with elapsed time cleared,
//   pause_ms to 150 and melody_length to 8, and empties the result buffer
// depends on mns_pkg, mns_tick_if, mns_note_if, mns_cfg, mns_core, mns_obuf
`timescale 1ns / 1ps
`default_nettype none
`include "melody_note_sequencer_macros.svh"
module melody_note_sequencer import mns_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mns_tick_if.sink                   tick,
  mns_note_if.source                 note,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t    cfg;
  result_t core_res;
  result_t buf_q;
  logic    buf_ready;
  logic    tick_accept;
  logic    note_accept;

  // a tick beat moves when the buffer has room
  assign tick.ready  = buf_ready;
  assign tick_accept = tick.valid && buf_ready;
  assign note_accept = note.valid && note.ready;

  // register block
  mns_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // player state and next-state logic, advanced once per accepted tick
  mns_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (tick_accept),
    .start_request (tick.start_request),
    .cfg           (cfg),
    .result        (core_res)
  );

  // result register with skid entry
  mns_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .push    (tick_accept),
    .d       (core_res),
    .ready   (buf_ready),
    .q_valid (note.valid),
    .pop     (note_accept),
    .q       (buf_q)
  );

  assign note.tone_frequency = buf_q.tone_frequency;
  assign note.tone_on        = buf_q.tone_on;
  assign note.note_started   = buf_q.note_started;
  assign note.player_state   = buf_q.player_state;
  assign note.note_position  = buf_q.note_position;

  // a note only starts into the playing state
  `MNS_ASSERT_NOW(a_start_playing, clk, rst,
    note.valid && note.note_started, note.player_state == ST_PLAYING)
  // a sounding tone needs a playing note with a nonzero frequency
  `MNS_ASSERT_NOW(a_tone_on_sane, clk, rst,
    note.valid && note.tone_on,
    (note.player_state == ST_PLAYING) && (note.tone_frequency != '0))
  // every accepted tick leaves a result beat valid on the next cycle
  `MNS_ASSERT_NEXT(a_result_follows, clk, rst, tick_accept, note.valid)

endmodule
`default_nettype wire

FILE: tb/tb_melody_note_sequencer.sv
// testbench for melody_note_sequencer: directed and random tick beats, checked
// beat by beat against an in-bench model of the note player
// depends on mns_pkg, mns_tick_if, mns_note_if and the melody_note_sequencer rtl
`timescale 1ns / 1ps
module tb_melody_note_sequencer;
  import mns_pkg::*;

  // no beat on any channel for this many cycles means the block is stuck
  localparam int WATCHDOG_LIMIT = 2000;
  // cap on printed mismatch lines
  localparam int MAX_REPORTS = 40;
  // notes in the fixed melody table
  localparam logic [3:0] TABLE_NOTES = 4'd8;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mns_tick_if tick_ch();
  mns_note_if note_ch();

  melody_note_sequencer u_dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .note    (note_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // player model state, mirrors what the block should hold
  logic [STATE_W-1:0] pl_mode;
  logic [IDX_W-1:0]   pl_note;
  logic [15:0]        pl_elapsed;
  logic [15:0]        cfg_pause_ms;
  logic [3:0]         cfg_melody_len;

  // note beats owed by the block, oldest first
  result_t pending_notes[$];

  int    mismatches;
  int    quiet_cycles;
  int    tick_gap_pct;
  int    note_stall_pct;
  int    hold_cycles;
  logic  note_ready_next;
  result_t want_note;

  always #4 clk = ~clk;

  // own copy of the melody: frequency in hz, 0 is a rest
  function automatic logic [FREQ_W-1:0] melody_freq(input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    case (idx)
      3'd0:    f = 14'd262;
      3'd1:    f = 14'd196;
      3'd2:    f = 14'd196;
      3'd3:    f = 14'd220;
      3'd4:    f = 14'd196;
      3'd5:    f = 14'd0;
      3'd6:    f = 14'd247;
      default: f = 14'd262;
    endcase
    return f;
  endfunction

  // note length in ms
  function automatic logic [15:0] melody_dur(input logic [IDX_W-1:0] idx);
    logic [15:0] d;
    case (idx)
      3'd1, 3'd2: d = 16'd125;
      default:    d = 16'd250;
    endcase
    return d;
  endfunction

  // one millisecond tick of the player; returns the note beat it produces
  function automatic result_t advance_player(input logic start);
    result_t    r;
    logic [3:0] play_len;
    logic       started;
    // length clamps to the table and never drops below one note
    play_len = (cfg_melody_len > TABLE_NOTES) ? TABLE_NOTES : cfg_melody_len;
    if (play_len == 4'd0) play_len = 4'd1;
    started = 1'b0;
    // elapsed time saturates
    if (pl_elapsed != 16'hFFFF) pl_elapsed = pl_elapsed + 16'd1;
    if (start && pl_mode != ST_PLAYING) begin
      // restart from note 0 out of pause or finish
      pl_note    = '0;
      pl_elapsed = '0;
      pl_mode    = ST_PLAYING;
      started    = 1'b1;
    end else if (pl_mode == ST_PLAYING) begin
      if (pl_elapsed > melody_dur(pl_note)) begin
        // last note, or length lowered below the current note: done
        if ({1'b0, pl_note} + 4'd1 >= play_len) begin
          pl_mode = ST_FINISHED;
        end else begin
          pl_mode    = ST_PAUSING;
          pl_elapsed = '0;
          pl_note    = pl_note + 3'd1;
        end
      end
    end else if (pl_mode == ST_PAUSING) begin
      // the gap has to be exceeded, not just reached
      if (pl_elapsed > cfg_pause_ms) begin
        pl_elapsed = '0;
        pl_mode    = ST_PLAYING;
        started    = 1'b1;
      end
    end
    r.tone_frequency = melody_freq(pl_note);
    r.tone_on        = (pl_mode == ST_PLAYING) && (r.tone_frequency != '0) &&
                       (pl_elapsed < melody_dur(pl_note));
    r.note_started   = started;
    r.player_state   = pl_mode;
    r.note_position  = pl_note;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  // compare every note beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && note_ch.valid && note_ch.ready) begin
      if (pending_notes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: note beat with nothing expected, expected none got freq %0d",
                   $time, note_ch.tone_frequency);
      end else begin
        want_note = pending_notes.pop_front();
        check_field("tone_frequency", int'(want_note.tone_frequency),
                    int'(note_ch.tone_frequency));
        check_field("tone_on", int'(want_note.tone_on), int'(note_ch.tone_on));
        check_field("note_started", int'(want_note.note_started),
                    int'(note_ch.note_started));
        check_field("player_state", int'(want_note.player_state),
                    int'(note_ch.player_state));
        check_field("note_position", int'(want_note.note_position),
                    int'(note_ch.note_position));
      end
    end
  end

  // watchdog: any beat on either channel counts as progress
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (note_ch.valid && note_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[melody_note_sequencer] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted down here
  always @(negedge clk) begin
    note_ready_next = ($urandom_range(99) >= note_stall_pct);
    if (hold_cycles > 0) begin
      note_ready_next = 1'b0;
      hold_cycles--;
    end
    note_ch.ready <= note_ready_next;
  end

  task automatic set_idling(input int gap_pct, input int stall_pct);
    tick_gap_pct   = gap_pct;
    note_stall_pct = stall_pct;
  endtask

  // offer one tick beat, wait for it to be taken, then predict its note beat
  task automatic send_tick(input logic start);
    @(negedge clk);
    while ($urandom_range(99) < tick_gap_pct) begin
      // start bit wiggles while valid is low, must be ignored
      tick_ch.valid         <= 1'b0;
      tick_ch.start_request <= 1'($urandom_range(1));
      @(negedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.start_request <= start;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    pending_notes.push_back(advance_player(start));
  endtask

  // stop offering and let every owed note beat drain
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // apb write: setup then access, register taken at the access edge
  task automatic reg_write(input logic idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_PAUSE_MS) cfg_pause_ms = value[15:0];
    else cfg_melody_len = value[3:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // plain ticks until the current note is over, so a start will take
  task automatic wait_out_note();
    while (pl_mode == ST_PLAYING) send_tick(1'b0);
  endtask

  // reset values, start from finished, start while playing
  task automatic test_start_handling();
    set_idling(0, 0);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    repeat (18) send_tick(1'($urandom_range(1)));
  endtask

  // end of the first note opens the gap; the next note starts once it is exceeded
  task automatic test_pause_gap();
    int n;
    set_idling(29, 29);
    reg_write(REG_PAUSE_MS, 32'd3);
    reg_write(REG_MELODY_LEN, 32'd8);
    wait_out_note();
    for (n = 0; n < 20 && pl_mode != ST_PLAYING; n++) send_tick(1'b0);
    repeat (2) send_tick(1'b0);
  endtask

  // length cut below the current note ends the melody at the note's end
  task automatic test_length_lowered();
    int n;
    set_idling(29, 29);
    reg_write(REG_MELODY_LEN, 32'd1);
    for (n = 0; n < 400 && pl_mode != ST_FINISHED; n++) send_tick(1'b0);
    repeat (5) send_tick(1'b0);
  endtask

  // receiver holds off long while ticks keep coming, input must back up
  task automatic test_backpressure();
    set_idling(0, 0);
    reg_write(REG_PAUSE_MS, 32'd0);
    reg_write(REG_MELODY_LEN, 32'd0);
    hold_cycles = 60;
    repeat (64) send_tick($urandom_range(9) == 0);
  endtask

  // random settings per round: a start, then mostly plain ticks, some noise
  task automatic test_random_sequences();
    int round;
    int n;
    int pick;
    int len;
    int gap;
    for (round = 0; round < 4; round++) begin
      case (round % 4)
        0: set_idling(0, 0);
        1: set_idling(74, 0);
        2: set_idling(0, 74);
        default: set_idling(29, 29);
      endcase
      pick = $urandom_range(9);
      if (pick < 6) len = $urandom_range(2, 1);
      else if (pick == 6) len = 0;
      else if (pick == 7) len = $urandom_range(15, 9);
      else if (pick == 8) len = $urandom_range(8, 3);
      else len = $urandom_range(15);
      gap = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(6);
      reg_write(REG_PAUSE_MS, gap);
      reg_write(REG_MELODY_LEN, len);
      send_tick(1'b1);
      for (n = 0; n < 10; n++) send_tick($urandom_range(49) == 0);
      settle();
    end
  endtask

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.start_request = 1'b0;
    note_ch.ready         = 1'b0;
    mismatches            = 0;
    quiet_cycles          = 0;
    hold_cycles           = 0;
    tick_gap_pct          = 0;
    note_stall_pct        = 0;
    // player after reset: finished at note 0, default gap and length
    pl_mode        = ST_FINISHED;
    pl_note        = '0;
    pl_elapsed     = '0;
    cfg_pause_ms   = 16'd150;
    cfg_melody_len = 4'd8;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_start_handling();
    settle();
    test_pause_gap();
    settle();
    test_length_lowered();
    settle();
    test_backpressure();
    settle();
    test_random_sequences();
    settle();

    if (mismatches == 0) begin
      $display("[melody_note_sequencer] OK");
    end else begin
      $display("[melody_note_sequencer] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/mns_pkg.sv
sv/mns_tick_if.sv
sv/mns_note_if.sv
sv/mns_cfg.sv
sv/mns_core.sv
sv/mns_obuf.sv
sv/melody_note_sequencer.sv
tb/tb_melody_note_sequencer.sv
